>>> rtl/siud_pkg.sv
// ----------------------------------------------------------------------------
// siud_pkg
// Shared codes for the set intersection / union / difference block.
// ----------------------------------------------------------------------------
package siud_pkg;

    // Command codes carried in the operation field
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD_A = 2'd1,
        OP_LOAD_B = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    // Set operation selected by a run item
    typedef enum logic [1:0] {
        SEL_INTER = 2'd0,
        SEL_UNION = 2'd1,
        SEL_DIFF  = 2'd2,
        SEL_NONE  = 2'd3
    } sel_t;

    localparam int ELEM_W = 32;

endpackage

>>> rtl/siud_if.sv
// ----------------------------------------------------------------------------
// siud_cmd_if / siud_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface siud_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] element;
    logic [1:0]         set_op;

    modport source (output valid, output operation, output element, output set_op,
                    input ready);
    modport sink   (input valid, input operation, input element, input set_op,
                    output ready);
endinterface

interface siud_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last;
    logic               empty_res;
    logic               overflow;

    modport source (output valid, output value, output last, output empty_res,
                    output overflow, input ready);
    modport sink   (input valid, input value, input last, input empty_res,
                    input overflow, output ready);
endinterface

>>> rtl/siud_ram.sv
// ----------------------------------------------------------------------------
// siud_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module siud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/set_intersect_union_difference.sv
// ----------------------------------------------------------------------------
// set_intersect_union_difference
// Loads two sets into RAMs A and B, then computes intersection, union or
// difference into a result RAM and streams the result items out.
// ----------------------------------------------------------------------------
// Clear and load items are handled in the idle state. A run first fills the
// result RAM and then streams it. For intersection and difference each
// element of A is searched for in B, which is scanned through its single
// read port one entry a cycle. Union copies A into the result RAM, then
// searches the result so far for each element of B, scanning the result RAM
// the same way. Streaming goes through a start state, then reads, loads and
// holds each result item until it is taken on the result channel; a run
// with an empty result gives one item flagged empty_res. A new command is
// taken only once the last result item of a run has been taken.
// ----------------------------------------------------------------------------
module set_intersect_union_difference
    import siud_pkg::*;
#(
    parameter int SET_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    siud_cmd_if.sink   cmd,
    siud_res_if.source res
);

    localparam int AW  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW  = $clog2(SET_DEPTH + 1);
    localparam int RD  = 2 * SET_DEPTH;
    localparam int RAW = $clog2(RD);
    localparam int RCW = $clog2(RD + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CPY_RD,
        S_CPY_WR,
        S_OUTER_RD,
        S_KEY,
        S_SCAN,
        S_DECIDE,
        S_EMIT_START,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_a_reg, count_a_next;
    logic [CW-1:0]       count_b_reg, count_b_next;
    logic                ovf_reg, ovf_next;
    logic [RCW-1:0]      rc_reg, rc_next;
    logic [1:0]          sel_reg, sel_next;
    logic                phase2_reg, phase2_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [RCW-1:0]      k_reg, k_next;
    logic                pv_reg, pv_next;
    logic                found_reg, found_next;
    logic [ELEM_W-1:0]   key_reg, key_next;
    logic [RCW-1:0]      e_reg, e_next;
    logic                out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]   out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;
    logic                out_empty_reg, out_empty_next;

    logic                a_we, b_we, r_we;
    logic [AW-1:0]       a_raddr, b_raddr;
    logic [RAW-1:0]      r_waddr, r_raddr;
    logic [ELEM_W-1:0]   r_wdata;
    logic [ELEM_W-1:0]   a_rdata, b_rdata, r_rdata;

    logic                cmd_fire;
    logic [CW-1:0]       i_inc;
    logic [CW-1:0]       outer_n;
    logic [RCW-1:0]      scan_n;
    logic [ELEM_W-1:0]   scan_data;
    logic                match;
    logic                push;
    logic                emit_phase;

    // Set stores and result store
    siud_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH), .AW(AW)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (cmd.element),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    siud_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH), .AW(AW)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (cmd.element),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    siud_ram #(.WIDTH(ELEM_W), .DEPTH(RD), .AW(RAW)) u_ram_r (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Handshake and RAM port steering
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && (state_reg == S_IDLE);
    assign emit_phase = (state_reg == S_EMIT_RD);

    assign a_we = cmd_fire && (cmd.operation == OP_LOAD_A) && (count_a_reg < DEPTH_C);
    assign b_we = cmd_fire && (cmd.operation == OP_LOAD_B) && (count_b_reg < DEPTH_C);

    assign i_inc     = i_reg + CW'(1);
    assign outer_n   = phase2_reg ? count_b_reg : count_a_reg;
    assign scan_n    = phase2_reg ? rc_reg : RCW'(count_b_reg);
    assign scan_data = phase2_reg ? r_rdata : b_rdata;
    assign match     = (scan_data == key_reg);
    assign push      = (sel_reg == SEL_INTER) ? found_reg : !found_reg;

    assign a_raddr = i_reg[AW-1:0];
    assign b_raddr = (state_reg == S_OUTER_RD) ? i_reg[AW-1:0] : k_reg[AW-1:0];
    assign r_raddr = emit_phase ? e_reg[RAW-1:0] : k_reg[RAW-1:0];
    assign r_waddr = rc_reg[RAW-1:0];
    assign r_we    = (state_reg == S_CPY_WR) || ((state_reg == S_DECIDE) && push);
    assign r_wdata = (state_reg == S_CPY_WR) ? a_rdata : key_reg;

    // Drive the result channel from the output register
    assign res.valid     = out_valid_reg;
    assign res.value     = out_value_reg;
    assign res.last      = out_last_reg;
    assign res.empty_res = out_empty_reg;
    assign res.overflow  = ovf_reg;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ovf_next       = ovf_reg;
        rc_next        = rc_reg;
        sel_next       = sel_reg;
        phase2_next    = phase2_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        pv_next        = pv_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.operation)
                        OP_CLEAR:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                            ovf_next     = 1'b0;
                        end
                        OP_LOAD_A:
                        begin
                            if (count_a_reg < DEPTH_C)
                                count_a_next = count_a_reg + CW'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        OP_LOAD_B:
                        begin
                            if (count_b_reg < DEPTH_C)
                                count_b_next = count_b_reg + CW'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        OP_RUN:
                        begin
                            rc_next     = '0;
                            i_next      = '0;
                            phase2_next = 1'b0;
                            sel_next    = cmd.set_op;
                            case (cmd.set_op)
                                SEL_INTER, SEL_DIFF:
                                begin
                                    state_next = (count_a_reg == '0) ? S_EMIT_START
                                                                     : S_OUTER_RD;
                                end
                                SEL_UNION:
                                begin
                                    if (count_a_reg != '0)
                                    begin
                                        state_next = S_CPY_RD;
                                    end
                                    else
                                    begin
                                        phase2_next = 1'b1;
                                        state_next  = (count_b_reg == '0) ? S_EMIT_START
                                                                          : S_OUTER_RD;
                                    end
                                end
                                default:
                                begin
                                    state_next = S_EMIT_START;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Copy A into the result store for union
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end

            S_CPY_WR:
            begin
                rc_next = rc_reg + RCW'(1);
                if (i_inc < count_a_reg)
                begin
                    i_next     = i_inc;
                    state_next = S_CPY_RD;
                end
                else
                begin
                    i_next      = '0;
                    phase2_next = 1'b1;
                    state_next  = (count_b_reg == '0) ? S_EMIT_START : S_OUTER_RD;
                end
            end

            // Fetch the next outer element as the search key
            S_OUTER_RD:
            begin
                state_next = S_KEY;
            end

            S_KEY:
            begin
                key_next   = phase2_reg ? b_rdata : a_rdata;
                k_next     = '0;
                pv_next    = 1'b0;
                found_next = 1'b0;
                state_next = (scan_n == '0) ? S_DECIDE : S_SCAN;
            end

            // Scan the inner list one entry a cycle
            S_SCAN:
            begin
                if (pv_reg && match)
                    found_next = 1'b1;
                if (k_reg < scan_n)
                begin
                    k_next  = k_reg + RCW'(1);
                    pv_next = 1'b1;
                end
                else
                begin
                    pv_next    = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            // Keep or drop the key, then advance
            S_DECIDE:
            begin
                if (push)
                    rc_next = rc_reg + RCW'(1);
                if (i_inc < outer_n)
                begin
                    i_next     = i_inc;
                    state_next = S_OUTER_RD;
                end
                else
                begin
                    state_next = S_EMIT_START;
                end
            end

            // Stream the result store
            S_EMIT_START:
            begin
                e_next = '0;
                if (rc_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = S_EMIT_HOLD;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT_LOAD;
            end

            S_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_value_next = r_rdata;
                out_last_next  = ((e_reg + RCW'(1)) == rc_reg);
                out_empty_next = 1'b0;
                state_next     = S_EMIT_HOLD;
            end

            S_EMIT_HOLD:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + RCW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ovf_reg       <= 1'b0;
            rc_reg        <= '0;
            sel_reg       <= '0;
            phase2_reg    <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            key_reg       <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            ovf_reg       <= ovf_next;
            rc_reg        <= rc_next;
            sel_reg       <= sel_next;
            phase2_reg    <= phase2_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            key_reg       <= key_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
        end
    end

endmodule

>>> rtl/siud_checker.sv
// ----------------------------------------------------------------------------
// siud_checker
// Port-level assertions for the set operation block, bound to the top level.
// ----------------------------------------------------------------------------
module siud_checker
    import siud_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  operation,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_value,
    input logic        res_last,
    input logic        res_empty_res
);

    // Hold a stalled result item
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value)
                                    && $stable(res_last) && $stable(res_empty_res))
        else $error("stalled result item changed");

    // Never take a command while a result item is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && res_valid))
        else $error("command accepted during result streaming");

    // An empty result is a single, final item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_empty_res |-> res_last)
        else $error("empty result item without last");

    // Clear and load items produce no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (operation != OP_RUN) |=> !res_valid)
        else $error("result item after a clear or load");

    // Stay busy until the last item of a run is taken
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> !cmd_ready)
        else $error("command ready in the middle of a run");

endmodule

bind set_intersect_union_difference siud_checker u_siud_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .operation     (cmd.operation),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_value     (res.value),
    .res_last      (res.last),
    .res_empty_res (res.empty_res)
);
